### rtl/wpp_pkg.sv
// Shared types and constants for the WAV header parser.
`default_nettype none
package wpp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] POS_HEADER_LAST = POS_W'(43);

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic {
    ST_HEADER,
    ST_DATA
  } ctrl_state_t;

  // What the datapath does with the header byte of the current beat.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAG_RIFF,
    OP_TAG_WAVE,
    OP_TAG_FMT,
    OP_CAP_FORMAT,
    OP_CAP_CHANNELS,
    OP_CAP_RATE,
    OP_CAP_BYTE_RATE,
    OP_CAP_ALIGN,
    OP_CAP_BITS,
    OP_TAG_DATA,
    OP_HEADER_LAST
  } field_op_t;

  typedef struct packed {
    logic      restart;
    logic      shift_en;
    field_op_t op;
    logic      data_take;
  } wpp_cmd_t;

  typedef struct packed {
    logic sample_emit;
  } wpp_status_t;

  typedef struct packed {
    logic               kind;
    logic               header_ok;
    logic [15:0]        audio_format;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_size;
    logic signed [63:0] sample_value;
  } wpp_result_t;

endpackage
`default_nettype wire

### rtl/wpp_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none
interface wpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface wpp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               header_ok;
  logic [15:0]        audio_format;
  logic [15:0]        channels;
  logic [31:0]        sample_rate;
  logic [15:0]        bits_per_sample;
  logic [31:0]        data_size;
  logic signed [63:0] sample_value;

  modport source (
    output valid, output kind, output header_ok, output audio_format, output channels,
    output sample_rate, output bits_per_sample, output data_size, output sample_value,
    input ready
  );
  modport sink (
    input valid, input kind, input header_ok, input audio_format, input channels,
    input sample_rate, input bits_per_sample, input data_size, input sample_value,
    output ready
  );
endinterface
`default_nettype wire

### rtl/wpp_ctrl.sv
// Controller: header byte position, parse phase and output handshake.
`default_nettype none
module wpp_ctrl
  import wpp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_frame_start,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output wpp_cmd_t   cmd,
  input  wpp_status_t status
);

  ctrl_state_t      state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] pos_eff;
  logic             in_header;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HEADER;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  // A frame start puts this very beat at byte 0 of a fresh header.
  assign in_header = in_frame_start || (state_r == ST_HEADER);
  assign pos_eff   = in_frame_start ? '0 : pos_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cmd.restart   = accept && in_frame_start;
    cmd.shift_en  = accept && in_header;
    cmd.data_take = accept && !in_header;
    cmd.op        = OP_NONE;

    if (in_header) begin
      unique case (pos_eff)
        POS_W'(3):       cmd.op = OP_TAG_RIFF;
        POS_W'(11):      cmd.op = OP_TAG_WAVE;
        POS_W'(15):      cmd.op = OP_TAG_FMT;
        POS_W'(21):      cmd.op = OP_CAP_FORMAT;
        POS_W'(23):      cmd.op = OP_CAP_CHANNELS;
        POS_W'(27):      cmd.op = OP_CAP_RATE;
        POS_W'(31):      cmd.op = OP_CAP_BYTE_RATE;
        POS_W'(33):      cmd.op = OP_CAP_ALIGN;
        POS_W'(35):      cmd.op = OP_CAP_BITS;
        POS_W'(39):      cmd.op = OP_TAG_DATA;
        POS_HEADER_LAST: cmd.op = OP_HEADER_LAST;
        default:         cmd.op = OP_NONE;
      endcase
    end

    if (accept && in_header) begin
      if (pos_eff == POS_HEADER_LAST) begin
        state_nxt = ST_DATA;
        pos_nxt   = pos_eff;
      end else begin
        state_nxt = ST_HEADER;
        pos_nxt   = pos_eff + POS_W'(1);
      end
    end

    if (accept && ((cmd.op == OP_HEADER_LAST) || status.sample_emit)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule
`default_nettype wire

### rtl/wpp_dp.sv
// Datapath: byte shifter, field capture, header checks, sample assembly, result register.
`default_nettype none
module wpp_dp
  import wpp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic [7:0] in_data_byte,
  input  wpp_cmd_t   cmd,
  output wpp_status_t status,
  output wpp_result_t result
);

  logic [31:0] shift_r;
  logic [3:0]  tags_r;
  logic [15:0] format_r, channels_r, align_r, bits_r;
  logic [31:0] rate_r, byte_rate_r, remaining_r;
  logic [63:0] gather_r;
  logic [2:0]  count_r;
  logic [28:0] exp_align_r;
  logic [31:0] exp_rate_r;
  logic [63:0] exp_rate_full;
  wpp_result_t result_r;

  logic [31:0] shift_base, shift_new;
  logic [15:0] half;
  logic [3:0]  tags_base;
  logic [12:0] bytes_per;
  logic [3:0]  need;
  logic [3:0]  idx_nxt;
  logic [63:0] gather_new;
  logic [63:0] sample_val;
  logic        header_ok;

  function automatic logic [28:0] bits_per_ext(input logic [12:0] v);
    bits_per_ext = {16'b0, v};
  endfunction

  assign shift_base = cmd.restart ? '0 : shift_r;
  assign shift_new  = {in_data_byte, shift_base[31:8]};
  assign half       = shift_new[31:16];
  assign tags_base  = cmd.restart ? 4'hF : tags_r;

  assign bytes_per = bits_r[15:3];
  always_comb begin
    case (bytes_per)
      13'd2:   need = 4'd2;
      13'd4:   need = 4'd4;
      13'd8:   need = 4'd8;
      default: need = 4'd1;
    endcase
  end

  assign idx_nxt    = {1'b0, count_r} + 4'd1;
  assign gather_new = gather_r | ({56'b0, in_data_byte} << {count_r, 3'b000});
  assign status.sample_emit = cmd.data_take && (remaining_r != '0) && (idx_nxt >= need);

  always_comb begin
    case (need)
      4'd2:    sample_val = {{48{gather_new[15]}}, gather_new[15:0]};
      4'd4:    sample_val = {{32{gather_new[31]}}, gather_new[31:0]};
      4'd8:    sample_val = gather_new;
      default: sample_val = {56'b0, gather_new[7:0]};
    endcase
  end

  // The checks settle through exp_align_r and then exp_rate_r after the last capture, long before byte 43.
  assign exp_rate_full = {35'b0, exp_align_r} * {32'b0, rate_r};
  always_ff @(posedge clk) begin
    exp_align_r <= channels_r * bits_per_ext(bytes_per);
    exp_rate_r  <= exp_rate_full[31:0];
  end

  assign header_ok = (tags_base == 4'hF) && (exp_align_r == {13'b0, align_r})
                     && (exp_rate_r == byte_rate_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      tags_r      <= 4'hF;
      format_r    <= '0;
      channels_r  <= '0;
      rate_r      <= '0;
      byte_rate_r <= '0;
      align_r     <= '0;
      bits_r      <= '0;
      remaining_r <= '0;
      gather_r    <= '0;
      count_r     <= '0;
    end else begin
      if (cmd.restart) begin
        tags_r <= 4'hF;
      end
      if (cmd.shift_en) begin
        shift_r <= shift_new;
        case (cmd.op)
          OP_TAG_RIFF:      tags_r <= tags_base & {3'b111, shift_new == TAG_RIFF};
          OP_TAG_WAVE:      tags_r <= tags_base & {2'b11, shift_new == TAG_WAVE, 1'b1};
          OP_TAG_FMT:       tags_r <= tags_base & {1'b1, shift_new == TAG_FMT, 2'b11};
          OP_TAG_DATA:      tags_r <= tags_base & {shift_new == TAG_DATA, 3'b111};
          OP_CAP_FORMAT:    format_r    <= half;
          OP_CAP_CHANNELS:  channels_r  <= half;
          OP_CAP_RATE:      rate_r      <= shift_new;
          OP_CAP_BYTE_RATE: byte_rate_r <= shift_new;
          OP_CAP_ALIGN:     align_r     <= half;
          OP_CAP_BITS:      bits_r      <= half;
          OP_HEADER_LAST: begin
            remaining_r <= shift_new;
            gather_r    <= '0;
            count_r     <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.data_take && (remaining_r != '0)) begin
        remaining_r <= remaining_r - 32'd1;
        if (idx_nxt >= need) begin
          gather_r <= '0;
          count_r  <= '0;
        end else begin
          gather_r <= gather_new;
          count_r  <= idx_nxt[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_en && (cmd.op == OP_HEADER_LAST)) begin
      result_r.kind            <= KIND_HEADER;
      result_r.header_ok       <= header_ok;
      result_r.audio_format    <= format_r;
      result_r.channels        <= channels_r;
      result_r.sample_rate     <= rate_r;
      result_r.bits_per_sample <= bits_r;
      result_r.data_size       <= shift_new;
      result_r.sample_value    <= '0;
    end else if (status.sample_emit) begin
      result_r.kind            <= KIND_SAMPLE;
      result_r.header_ok       <= 1'b0;
      result_r.audio_format    <= '0;
      result_r.channels        <= '0;
      result_r.sample_rate     <= '0;
      result_r.bits_per_sample <= '0;
      result_r.data_size       <= '0;
      result_r.sample_value    <= sample_val;
    end
  end

  assign result = result_r;

endmodule
`default_nettype wire

### rtl/wav_pcm_header_parser_core.sv
// Throughput: one file byte per cycle while results are taken as they appear.
// Latency: a result is presented on the cycle after the byte that completes it
// (byte 43 for the header verdict, the last byte of a sample for a sample).
// A waiting result holds off the next byte only while out_ready is low.
// The rate and alignment products are registered every cycle from the captured fields.
// Reset (synchronous, active low) returns the parser to byte 0 with no result pending.
`default_nettype none
module wav_pcm_header_parser_core
  import wpp_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  wpp_in_if.sink     in_ch,
  wpp_out_if.source  out_ch
);

  wpp_cmd_t    cmd;
  wpp_status_t status;
  wpp_result_t result;

  wpp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_frame_start (in_ch.frame_start),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cmd            (cmd),
    .status         (status)
  );

  wpp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_ch.data_byte),
    .cmd          (cmd),
    .status       (status),
    .result       (result)
  );

  assign out_ch.kind            = result.kind;
  assign out_ch.header_ok       = result.header_ok;
  assign out_ch.audio_format    = result.audio_format;
  assign out_ch.channels        = result.channels;
  assign out_ch.sample_rate     = result.sample_rate;
  assign out_ch.bits_per_sample = result.bits_per_sample;
  assign out_ch.data_size       = result.data_size;
  assign out_ch.sample_value    = result.sample_value;

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the WAV header parser: file byte streams in, results scoreboarded.
`default_nettype none
module tb;
  import wpp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [POS_W-1:0] POS_DATA = POS_HEADER_LAST + POS_W'(1);

  // Canonical 44-byte header laid out so that byte i is bits [8*i +: 8].
  typedef struct packed {
    logic [31:0] data_size;
    logic [31:0] data_tag;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] byte_rate;
    logic [31:0] rate;
    logic [15:0] channels;
    logic [15:0] format;
    logic [31:0] fmt_size;
    logic [31:0] fmt_tag;
    logic [31:0] wave_tag;
    logic [31:0] riff_size;
    logic [31:0] riff_tag;
  } wav_hdr_t;

  typedef logic [7:0] file_bytes_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid_q = 1'b0;
  logic [7:0] in_byte_q = 8'h00;
  logic       in_start_q = 1'b0;
  logic       out_ready_q = 1'b0;

  wpp_in_if  in_ch();
  wpp_out_if out_ch();

  assign in_ch.valid       = in_valid_q;
  assign in_ch.data_byte   = in_byte_q;
  assign in_ch.frame_start = in_start_q;
  assign out_ch.ready      = out_ready_q;

  wav_pcm_header_parser_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state as the byte stream is taken.
  logic [POS_W-1:0] hdr_pos = '0;
  logic [3:0]       tag_ok = 4'hF;
  logic [31:0]      shift_win = '0;
  logic [15:0]      cap_format = '0;
  logic [15:0]      cap_channels = '0;
  logic [31:0]      cap_rate = '0;
  logic [31:0]      cap_byte_rate = '0;
  logic [15:0]      cap_align = '0;
  logic [15:0]      cap_bits = '0;
  logic [31:0]      data_left = '0;
  logic [63:0]      smp_acc = '0;
  logic [2:0]       smp_cnt = '0;

  wpp_result_t pending_results[$];
  int mismatch_count = 0;
  int header_count = 0;
  int sample_count = 0;
  int headers_sent = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int ready_stall_pct = 0;
  int stall_left = 0;

  function automatic void restart_parse();
    hdr_pos = '0;
    tag_ok = 4'hF;
    shift_win = '0;
    smp_acc = '0;
    smp_cnt = '0;
  endfunction

  function automatic int unsigned bytes_per_sample();
    logic [12:0] k;
    k = cap_bits[15:3];
    if (k == 13'd2 || k == 13'd4 || k == 13'd8) return int'(k);
    return 1;
  endfunction

  // Advances the parser state by one byte; returns 1 when the byte completes a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic fs, output wpp_result_t r);
    logic [31:0] exp_align;
    logic [31:0] exp_rate;
    logic [63:0] v;
    int unsigned k;
    int unsigned idx;
    r = '0;
    if (fs) restart_parse();
    if (hdr_pos < POS_DATA) begin
      shift_win = {b, shift_win[31:8]};
      case (hdr_pos)
        6'd3:  if (shift_win != TAG_RIFF) tag_ok[0] = 1'b0;
        6'd11: if (shift_win != TAG_WAVE) tag_ok[1] = 1'b0;
        6'd15: if (shift_win != TAG_FMT) tag_ok[2] = 1'b0;
        6'd21: cap_format = shift_win[31:16];
        6'd23: cap_channels = shift_win[31:16];
        6'd27: cap_rate = shift_win;
        6'd31: cap_byte_rate = shift_win;
        6'd33: cap_align = shift_win[31:16];
        6'd35: cap_bits = shift_win[31:16];
        6'd39: if (shift_win != TAG_DATA) tag_ok[3] = 1'b0;
        default: ;
      endcase
      if (hdr_pos == POS_HEADER_LAST) begin
        exp_align = {16'h0, cap_channels} * {19'h0, cap_bits[15:3]};
        exp_rate = exp_align * cap_rate;
        data_left = shift_win;
        smp_acc = '0;
        smp_cnt = '0;
        hdr_pos = POS_DATA;
        r.kind = KIND_HEADER;
        r.header_ok = (tag_ok == 4'hF) && (exp_align == {16'h0, cap_align}) &&
                      (exp_rate == cap_byte_rate);
        r.audio_format = cap_format;
        r.channels = cap_channels;
        r.sample_rate = cap_rate;
        r.bits_per_sample = cap_bits;
        r.data_size = data_left;
        return 1'b1;
      end
      hdr_pos = hdr_pos + POS_W'(1);
      return 1'b0;
    end
    if (data_left == 32'd0) return 1'b0;
    data_left = data_left - 32'd1;
    k = bytes_per_sample();
    idx = smp_cnt;
    smp_acc = smp_acc | (64'(b) << (8 * idx));
    idx = idx + 1;
    if (idx < k) begin
      smp_cnt = 3'(idx);
      return 1'b0;
    end
    case (k)
      2: v = {{48{smp_acc[15]}}, smp_acc[15:0]};
      4: v = {{32{smp_acc[31]}}, smp_acc[31:0]};
      8: v = smp_acc;
      default: v = {56'h0, smp_acc[7:0]};
    endcase
    smp_acc = '0;
    smp_cnt = '0;
    r.kind = KIND_SAMPLE;
    r.sample_value = v;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Results are checked before the byte of the same edge is predicted: a result can
  // only belong to a byte taken on an earlier edge.
  always @(posedge clk) begin
    wpp_result_t want;
    wpp_result_t next;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected (kind %0d)", out_ch.kind);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_ch.kind));
          check_field("header_ok", 64'(want.header_ok), 64'(out_ch.header_ok));
          check_field("audio_format", 64'(want.audio_format), 64'(out_ch.audio_format));
          check_field("channels", 64'(want.channels), 64'(out_ch.channels));
          check_field("sample_rate", 64'(want.sample_rate), 64'(out_ch.sample_rate));
          check_field("bits_per_sample", 64'(want.bits_per_sample),
                      64'(out_ch.bits_per_sample));
          check_field("data_size", 64'(want.data_size), 64'(out_ch.data_size));
          check_field("sample_value", want.sample_value, out_ch.sample_value);
          if (want.kind == KIND_HEADER) header_count++;
          else sample_count++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.data_byte, in_ch.frame_start, next))
          pending_results.push_back(next);
      end
    end
  end

  // Receiver stalls come in bursts; ready_stall_pct sets how often a burst begins.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_q <= 1'b0;
    end else if ($urandom_range(0, 99) < ready_stall_pct) begin
      stall_left <= $urandom_range(0, 15);
      out_ready_q <= 1'b0;
    end else begin
      out_ready_q <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Presents one byte and holds it until the beat is taken, then maybe idles.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    in_valid_q <= 1'b1;
    in_byte_q <= b;
    in_start_q <= fs;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 16);
      in_valid_q <= 1'b0;
      in_byte_q <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_header(input wav_hdr_t h, input logic fs, input int n);
    for (int i = 0; i < n; i++) send_byte(h[8*i +: 8], (i == 0) ? fs : 1'b0);
    headers_sent++;
  endtask

  task automatic send_data(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_bytes(input file_bytes_t q);
    foreach (q[i]) send_byte(q[i], 1'b0);
  endtask

  task automatic drain_results();
    in_valid_q <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic wav_hdr_t make_hdr(input logic [15:0] fmt, ch, input logic [31:0] rate,
                                        input logic [15:0] bits, input logic [31:0] dsize);
    wav_hdr_t h;
    logic [31:0] align_full;
    align_full = {16'h0, ch} * {19'h0, bits[15:3]};
    h.riff_tag = TAG_RIFF;
    h.riff_size = dsize + 32'd36;
    h.wave_tag = TAG_WAVE;
    h.fmt_tag = TAG_FMT;
    h.fmt_size = 32'd16;
    h.format = fmt;
    h.channels = ch;
    h.rate = rate;
    h.byte_rate = align_full * rate;
    h.align = align_full[15:0];
    h.bits = bits;
    h.data_tag = TAG_DATA;
    h.data_size = dsize;
    return h;
  endfunction

  // After reset the parser sits at byte 0, so the first file needs no start flag.
  task automatic test_start_without_flag();
    wav_hdr_t h;
    h = make_hdr(16'd1, 16'd2, 32'd44100, 16'd16, 32'd8);
    send_header(h, 1'b0, 44);
    send_bytes({8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00});
  endtask

  task automatic test_sample_widths();
    wav_hdr_t h;
    h = make_hdr(16'd1, 16'd1, 32'd8000, 16'd8, 32'd4);
    send_header(h, 1'b1, 44);
    send_bytes({8'h00, 8'hFF, 8'h80, 8'h7F});
    h = make_hdr(16'd3, 16'd1, 32'd48000, 16'd32, 32'd8);
    send_header(h, 1'b1, 44);
    send_bytes({8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
    h = make_hdr(16'd1, 16'd1, 32'd96000, 16'd64, 32'd24);
    send_header(h, 1'b1, 44);
    send_bytes({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
  endtask

  // Widths outside 2, 4 and 8 bytes fall back to unsigned single bytes;
  // 17 and 71 bits still round down to 2 and 8 bytes.
  task automatic test_odd_widths();
    wav_hdr_t h;
    h = make_hdr(16'd1, 16'd2, 32'd44100, 16'd24, 32'd4);
    send_header(h, 1'b1, 44);
    send_bytes({8'hFF, 8'h80, 8'h01, 8'h7F});
    h = make_hdr(16'd1, 16'd1, 32'd8000, 16'd0, 32'd2);
    send_header(h, 1'b1, 44);
    send_bytes({8'h80, 8'hFF});
    h = make_hdr(16'd1, 16'd1, 32'd8000, 16'd17, 32'd4);
    send_header(h, 1'b1, 44);
    send_bytes({8'h00, 8'h80, 8'h34, 8'h12});
    h = make_hdr(16'd1, 16'd1, 32'd8000, 16'd71, 32'd8);
    send_header(h, 1'b1, 44);
    send_data(8);
  endtask

  // A bad verdict still lets the samples through.
  task automatic test_bad_header();
    wav_hdr_t h;
    for (int t = 0; t < 6; t++) begin
      h = make_hdr(16'd1, 16'd2, 32'd22050, 16'd16, 32'd4);
      case (t)
        0: h.riff_tag = h.riff_tag ^ (32'h1 << $urandom_range(0, 31));
        1: h.wave_tag = h.wave_tag ^ (32'h1 << $urandom_range(0, 31));
        2: h.fmt_tag = h.fmt_tag ^ (32'h1 << $urandom_range(0, 31));
        3: h.data_tag = h.data_tag ^ (32'h1 << $urandom_range(0, 31));
        4: h.align = h.align + 16'd1;
        default: h.byte_rate = h.byte_rate ^ 32'h1;
      endcase
      send_header(h, 1'b1, 44);
      send_data(4);
    end
  endtask

  task automatic test_field_extremes();
    wav_hdr_t h;
    h = '1;
    send_header(h, 1'b1, 44);
    send_data(6);
    h = '0;
    send_header(h, 1'b1, 44);
    send_data(3);
    // Zero channels and zero bits make both checks trivially hold.
    h = make_hdr(16'd0, 16'd0, 32'd0, 16'd0, 32'd0);
    send_header(h, 1'b1, 44);
    // Alignment overflows 16 bits, so it can never match the captured field.
    h = make_hdr(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd16, 32'd2);
    send_header(h, 1'b1, 44);
    send_data(2);
  endtask

  task automatic test_trailing_bytes();
    wav_hdr_t h;
    h = make_hdr(16'd1, 16'd2, 32'd22050, 16'd16, 32'd5);
    send_header(h, 1'b1, 44);
    send_data(8);
    h = make_hdr(16'd1, 16'd1, 32'd16000, 16'd32, 32'd0);
    send_header(h, 1'b1, 44);
    send_data(5);
  endtask

  task automatic test_restart();
    wav_hdr_t h;
    h = make_hdr(16'd1, 16'd2, 32'd48000, 16'd16, 32'd8);
    send_header(h, 1'b1, 20);
    h = make_hdr(16'd1, 16'd1, 32'd48000, 16'd32, 32'd16);
    send_header(h, 1'b1, 44);
    send_data(6);
    h = make_hdr(16'd1, 16'd1, 32'd32000, 16'd16, 32'hFFFF_FFFF);
    send_header(h, 1'b1, 44);
    send_data(9);
    h = make_hdr(16'd1, 16'd2, 32'd44100, 16'd16, 32'd4);
    send_header(h, 1'b1, 44);
    send_data(4);
  endtask

  task automatic test_random_files(input int byte_goal, input bit with_idling);
    wav_hdr_t h;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] dsize;
    int counted;
    int n;
    int ndata;
    counted = 0;
    while (counted < byte_goal) begin
      if (with_idling) begin
        send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        ready_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      end
      if ($urandom_range(0, 19) == 0) begin
        // Raw noise with stray start flags.
        n = $urandom_range(8, 60);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom), (i == 0) || ($urandom_range(0, 7) == 0));
        counted += n;
      end else begin
        ch = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
        case ($urandom_range(0, 9))
          0, 1:    bits = 16'd8;
          2, 3, 4: bits = 16'd16;
          5, 6:    bits = 16'd32;
          7:       bits = 16'd64;
          8:       bits = 16'd24;
          default: bits = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: rate = 32'd8000;
          1: rate = 32'd44100;
          2: rate = 32'd48000;
          default: rate = $urandom;
        endcase
        case ($urandom_range(0, 19))
          0: dsize = 32'd0;
          1: dsize = $urandom;
          default: dsize = 32'($urandom_range(1, 32));
        endcase
        h = make_hdr(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1, ch, rate, bits,
                     dsize);
        if ($urandom_range(0, 1) == 0) h.riff_size = $urandom;
        if ($urandom_range(0, 3) == 0) h.fmt_size = $urandom;
        if ($urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 5))
            0: h.riff_tag = h.riff_tag ^ (32'h1 << $urandom_range(0, 31));
            1: h.wave_tag = h.wave_tag ^ (32'h1 << $urandom_range(0, 31));
            2: h.fmt_tag = h.fmt_tag ^ (32'h1 << $urandom_range(0, 31));
            3: h.data_tag = h.data_tag ^ (32'h1 << $urandom_range(0, 31));
            4: h.align = 16'($urandom);
            default: h.byte_rate = $urandom;
          endcase
        end
        if ($urandom_range(0, 11) == 0) begin
          n = $urandom_range(1, 43);
          send_header(h, 1'b1, n);
          counted += n;
        end else begin
          send_header(h, 1'b1, 44);
          counted += 44;
          ndata = (dsize > 32'd64) ? $urandom_range(10, 60) : int'(dsize);
          if (ndata > 1 && $urandom_range(0, 7) == 0) begin
            ndata = $urandom_range(1, ndata - 1);
            send_data(ndata);
          end else begin
            send_data(ndata);
            // Bytes past the data chunk are ignored and do not count.
            if (dsize <= 32'd64) send_data($urandom_range(0, 3));
          end
          counted += ndata;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 20;
    ready_stall_pct = 20;
    test_start_without_flag();
    test_sample_widths();
    test_odd_widths();
    // Let everything outstanding arrive before the sender carries on.
    drain_results();
    test_bad_header();
    test_field_extremes();
    test_trailing_bytes();
    test_restart();
    drain_results();
    send_gap_pct = 0;
    ready_stall_pct = 0;
    test_random_files(40, 1'b0);
    in_valid_q <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Streamed %0d bytes in %0d headers, full and cut short, with bad tags and checks.",
             bytes_sent, headers_sent);
    $display("Checked %0d header verdicts and %0d samples of 1, 2, 4 and 8 bytes.",
             header_count, sample_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
rtl/wpp_pkg.sv
rtl/wpp_if.sv
rtl/wpp_ctrl.sv
rtl/wpp_dp.sv
rtl/wav_pcm_header_parser_core.sv
tb/tb.sv
